### rtl/core/ats_pkg.sv
// Shared constants and types for the array table search engine.
`default_nettype none

package ats_pkg;

    // Table geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths fixed by the interface
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 10;
    localparam int PROBE_W  = 11;
    localparam int COUNT_W  = 11;

    // Packed stream widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_BITS   = 1 + POS_W + PROBE_W + 1 + COUNT_W + 4 * WORD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_LINEAR = 3'd2,
        CMD_SORTED = 3'd3,
        CMD_BINARY = 3'd4
    } t_cmd;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIN,
        ST_BIN,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/core/ats_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module ats_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### rtl/core/array_table_search_engine.sv
// Top level of the array table search engine: command sequencer around the entry RAM.
//
// Input stream (s side): tuser carries the command, tdata the 32-bit word to
// append or the key to search for. Output stream (m side): one result per
// request with the search outcome and the table statistics after it.
// Append, clear and unused commands pass from the accepting state straight to
// the emit state, which loads the output register. Linear searches probe one
// entry per cycle, binary search one midpoint per cycle, through the single
// read port of the entry RAM; the emit state follows the last probe.
// One request is worked on at a time; tready returns as soon as the result
// has moved into the output register, so the next request is taken while a
// result still waits there. If the receiver stalls, a finished result waits
// in the sequencer until the output register frees up.
// Synchronous reset empties the table (count 0, statistics 0, product 1);
// the RAM contents are not cleared, since only entries below the fill count
// are ever compared.
`default_nettype none

module array_table_search_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [31:0]                   i_s_tdata,  // [31:0] key_value
    input  wire logic [2:0]                    i_s_tuser,  // [2:0] command
    // result channel
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [0] found, [10:1] position, [21:11] probes, [22] full_error,
    // [33:23] entry_count, [65:34] largest, [97:66] smallest,
    // [129:98] total, [161:130] product_word, [167:162] zero
    output logic [ats_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    import ats_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [WORD_W-1:0]  r_key, n_key;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0]  r_lo, n_lo;
    logic [ADDR_W-1:0]  r_hi, n_hi;
    logic [CNT_W-1:0]   r_probes, n_probes;
    logic               r_found, n_found;
    logic               r_full, n_full;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [WORD_W-1:0]  r_max, n_max;
    logic [WORD_W-1:0]  r_min, n_min;
    logic [WORD_W-1:0]  r_sum, n_sum;
    logic [WORD_W-1:0]  r_prod, n_prod;
    logic               r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [WORD_W-1:0]  ram_rdata;

    logic [CNT_W-1:0]   w_last;
    logic [ADDR_W:0]    w_mid_sum;
    logic [63:0]        w_prod_full;
    t_cmd               w_cmd;

    // Entry store
    ats_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_s_tdata),
        .o_rdata (ram_rdata)
    );

    assign w_cmd       = t_cmd'(i_s_tuser);
    assign w_last      = r_fill - CNT_W'(1);
    assign w_prod_full = {32'd0, r_prod} * {32'd0, i_s_tdata};

    // State and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_sum       <= '0;
            r_prod      <= WORD_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_max       <= n_max;
            r_min       <= n_min;
            r_sum       <= n_sum;
            r_prod      <= n_prod;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_probes   <= n_probes;
        r_found    <= n_found;
        r_full     <= n_full;
        r_out_data <= n_out_data;
    end

    // Sequencer: command decode, probe loop, result hand-off
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_probes    = r_probes;
        n_found     = r_found;
        n_full      = r_full;
        n_fill      = r_fill;
        n_max       = r_max;
        n_min       = r_min;
        n_sum       = r_sum;
        n_prod      = r_prod;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_addr    = r_idx;
        w_mid_sum   = '0;
        o_s_tready  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_cmd    = w_cmd;
                    n_key    = i_s_tdata;
                    n_found  = 1'b0;
                    n_full   = 1'b0;
                    n_probes = '0;
                    n_idx    = '0;
                    n_state  = ST_EMIT;
                    case (w_cmd)
                        CMD_APPEND: begin
                            if (r_fill >= CAP_CNT) begin
                                n_full = 1'b1;
                            end else begin
                                ram_we   = 1'b1;
                                ram_addr = r_fill[ADDR_W-1:0];
                                if (r_fill == '0) begin
                                    n_max = i_s_tdata;
                                    n_min = i_s_tdata;
                                end else begin
                                    if ($signed(r_max) < $signed(i_s_tdata)) n_max = i_s_tdata;
                                    if ($signed(i_s_tdata) < $signed(r_min)) n_min = i_s_tdata;
                                end
                                n_sum  = r_sum + i_s_tdata;
                                n_prod = w_prod_full[WORD_W-1:0];
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_fill = '0;
                            n_max  = '0;
                            n_min  = '0;
                            n_sum  = '0;
                            n_prod = WORD_W'(1);
                        end
                        CMD_LINEAR, CMD_SORTED: begin
                            if (r_fill != '0) begin
                                ram_addr = '0;
                                n_state  = ST_LIN;
                            end
                        end
                        CMD_BINARY: begin
                            if (r_fill != '0) begin
                                n_lo     = '0;
                                n_hi     = w_last[ADDR_W-1:0];
                                n_idx    = w_last[ADDR_W:1];
                                ram_addr = n_idx;
                                n_state  = ST_BIN;
                            end
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end

            // One entry compared per cycle, next read issued alongside
            ST_LIN: begin
                n_probes = r_probes + CNT_W'(1);
                if (ram_rdata == r_key) begin
                    n_found = 1'b1;
                    n_state = ST_EMIT;
                end else if (r_cmd == CMD_SORTED && $signed(r_key) < $signed(ram_rdata)) begin
                    n_state = ST_EMIT;
                end else if ({1'b0, r_idx} + CNT_W'(1) == r_fill) begin
                    n_state = ST_EMIT;
                end else begin
                    n_idx    = r_idx + ADDR_W'(1);
                    ram_addr = n_idx;
                end
            end

            // One midpoint compared per cycle, next midpoint read alongside
            ST_BIN: begin
                n_probes = r_probes + CNT_W'(1);
                if (ram_rdata == r_key) begin
                    n_found = 1'b1;
                    n_state = ST_EMIT;
                end else if ($signed(ram_rdata) < $signed(r_key)) begin
                    if (r_idx == r_hi) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_lo      = r_idx + ADDR_W'(1);
                        w_mid_sum = {1'b0, n_lo} + {1'b0, r_hi};
                        n_idx     = w_mid_sum[ADDR_W:1];
                        ram_addr  = n_idx;
                    end
                end else begin
                    if (r_idx == r_lo) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_hi      = r_idx - ADDR_W'(1);
                        w_mid_sum = {1'b0, r_lo} + {1'b0, n_hi};
                        n_idx     = w_mid_sum[ADDR_W:1];
                        ram_addr  = n_idx;
                    end
                end
            end

            // Move the result into the output register once it is free
            ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {
                        (OUT_DATA_W - OUT_BITS)'(0),
                        r_prod, r_sum, r_min, r_max,
                        COUNT_W'(r_fill),
                        r_full,
                        PROBE_W'(r_probes),
                        r_found ? POS_W'(r_idx) : POS_W'(0),
                        r_found
                    };
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP_CNT)
        else $error("fill count above capacity");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIN || r_state == ST_BIN) |-> ({1'b0, r_idx} < r_fill))
        else $error("probe index outside filled part");

    a_found_probed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> (r_out_data[21:11] != '0))
        else $error("match reported without a probe");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[22]) |-> (r_out_data[33:23] == COUNT_W'(CAPACITY)))
        else $error("full flag with table not full");

endmodule

`default_nettype wire

### test/tb_array_table_search_engine.sv
// Self-checking stream testbench for the array table search engine.
`default_nettype none

module tb_array_table_search_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ats_pkg::*;

    // Command codes the block does not define; they must leave the table alone
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 240;
    localparam int FILL_WORDS   = 300;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT     = 33;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] key;
        logic              drain_first;   // hold off until all results are back
    } t_request;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [PROBE_W-1:0] probes;
        logic               full_error;
        logic [COUNT_W-1:0] entry_count;
        logic [WORD_W-1:0]  largest;
        logic [WORD_W-1:0]  smallest;
        logic [WORD_W-1:0]  total;
        logic [WORD_W-1:0]  product_word;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [31:0]            i_s_tdata = '0;   // [31:0] key_value
    logic [2:0]             i_s_tuser = '0;   // [2:0] command
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [0] found, [10:1] position, [21:11] probes, [22] full_error,
    // [33:23] entry_count, [65:34] largest, [97:66] smallest,
    // [129:98] total, [161:130] product_word, [167:162] zero
    logic [OUT_DATA_W-1:0]  o_m_tdata;

    t_request request_queue[$];
    t_outcome pending_results[$];
    int       error_count = 0;
    int       cycle_cnt = 0;
    logic     req_fire = 1'b0;
    logic     steady;

    // Predicted table contents and statistics
    logic [WORD_W-1:0] table_words [0:CAPACITY-1];
    int                table_fill = 0;
    logic [WORD_W-1:0] run_max = '0;
    logic [WORD_W-1:0] run_min = '0;
    logic [WORD_W-1:0] run_sum = '0;
    logic [WORD_W-1:0] run_prod = 32'd1;

    array_table_search_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // No idling on either side inside this window
    assign steady = (cycle_cnt >= 600) && (cycle_cnt < 1600);

    // Applies one request to the predicted table and returns its result
    function automatic t_outcome run_table_command(logic [CMD_W-1:0] cmd,
                                                   logic [WORD_W-1:0] key);
        t_outcome r;
        int lo, hi, mid;
        r = '0;
        case (cmd)
            CMD_APPEND: begin
                if (table_fill >= CAPACITY) begin
                    r.full_error = 1'b1;
                end else begin
                    table_words[table_fill] = key;
                    if (table_fill == 0) begin
                        run_max = key;
                        run_min = key;
                    end else begin
                        if ($signed(key) > $signed(run_max)) run_max = key;
                        if ($signed(key) < $signed(run_min)) run_min = key;
                    end
                    run_sum  = run_sum + key;
                    run_prod = run_prod * key;
                    table_fill++;
                end
            end
            CMD_CLEAR: begin
                table_fill = 0;
                run_max  = '0;
                run_min  = '0;
                run_sum  = '0;
                run_prod = 32'd1;
            end
            CMD_LINEAR, CMD_SORTED: begin
                for (int i = 0; i < table_fill; i++) begin
                    r.probes = r.probes + 1'b1;
                    if (table_words[i] == key) begin
                        r.found    = 1'b1;
                        r.position = i[POS_W-1:0];
                        break;
                    end
                    // sorted scan gives up at the first larger entry
                    if (cmd == CMD_SORTED && $signed(key) < $signed(table_words[i])) break;
                end
            end
            CMD_BINARY: begin
                lo = 0;
                hi = table_fill - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    r.probes = r.probes + 1'b1;
                    if (table_words[mid] == key) begin
                        r.found    = 1'b1;
                        r.position = mid[POS_W-1:0];
                        break;
                    end
                    if ($signed(table_words[mid]) < $signed(key)) lo = mid + 1;
                    else hi = mid - 1;
                end
            end
            default: ;
        endcase
        r.entry_count  = table_fill[COUNT_W-1:0];
        r.largest      = run_max;
        r.smallest     = run_min;
        r.total        = run_sum;
        r.product_word = run_prod;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
            error_count++;
        end
    endtask

    task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] key,
                                 input logic drain);
        t_request r;
        r.cmd = cmd;
        r.key = key;
        r.drain_first = drain;
        request_queue.push_back(r);
    endtask

    // Request driver: holds a request until taken, idles and pauses on demand
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_s_tvalid && !req_fire)) begin
            if (request_queue.size() != 0
                && !(request_queue[0].drain_first && pending_results.size() != 0)
                && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                i_s_tuser  <= request_queue[0].cmd;
                i_s_tdata  <= request_queue[0].key;
                i_s_tvalid <= 1'b1;
                void'(request_queue.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result monitor: checks each result, then predicts for a taken request
    always @(posedge i_clk) begin : result_monitor
        t_outcome want, seen;
        cycle_cnt <= cycle_cnt + 1;
        req_fire  <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.found        = o_m_tdata[0];
            seen.position     = o_m_tdata[10:1];
            seen.probes       = o_m_tdata[21:11];
            seen.full_error   = o_m_tdata[22];
            seen.entry_count  = o_m_tdata[33:23];
            seen.largest      = o_m_tdata[65:34];
            seen.smallest     = o_m_tdata[97:66];
            seen.total        = o_m_tdata[129:98];
            seen.product_word = o_m_tdata[161:130];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %0h", $time, o_m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("found",        32'(want.found),       32'(seen.found));
                check_field("position",     32'(want.position),    32'(seen.position));
                check_field("probes",       32'(want.probes),      32'(seen.probes));
                check_field("full_error",   32'(want.full_error),  32'(seen.full_error));
                check_field("entry_count",  32'(want.entry_count), 32'(seen.entry_count));
                check_field("largest",      want.largest,          seen.largest);
                check_field("smallest",     want.smallest,         seen.smallest);
                check_field("total",        want.total,            seen.total);
                check_field("product_word", want.product_word,     seen.product_word);
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready)
            pending_results.push_back(run_table_command(i_s_tuser, i_s_tdata));
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [WORD_W-1:0] shadow[$];
        logic [WORD_W-1:0] val, key, first_word, last_word;
        logic [CMD_W-1:0]  cmd;
        longint            acc;
        int                base, n, m, kind, mode;

        // Directed: empty table, signed extremes, duplicates, unsorted, spare codes
        queue_request(CMD_LINEAR, 32'd0, 1'b0);
        queue_request(CMD_SORTED, 32'hFFFF_FFFF, 1'b0);
        queue_request(CMD_BINARY, 32'h8000_0000, 1'b0);
        queue_request(CMD_SPARE_5, $urandom, 1'b0);
        queue_request(CMD_APPEND, 32'h7FFF_FFFF, 1'b0);
        queue_request(CMD_APPEND, 32'h8000_0000, 1'b0);
        queue_request(CMD_APPEND, 32'd0, 1'b0);
        queue_request(CMD_APPEND, 32'hFFFF_FFFF, 1'b0);
        queue_request(CMD_APPEND, 32'd5, 1'b0);
        queue_request(CMD_APPEND, 32'd5, 1'b0);
        queue_request(CMD_LINEAR, 32'd5, 1'b0);
        queue_request(CMD_SORTED, 32'hFFFF_FFFF, 1'b0);
        queue_request(CMD_BINARY, 32'd0, 1'b0);
        queue_request(CMD_LINEAR, 32'd12345, 1'b0);
        queue_request(CMD_SPARE_6, $urandom, 1'b0);
        queue_request(CMD_SPARE_7, $urandom, 1'b0);
        queue_request(CMD_CLEAR, $urandom, 1'b0);
        queue_request(CMD_APPEND, 32'd3, 1'b0);
        queue_request(CMD_SORTED, 32'd3, 1'b0);
        queue_request(CMD_BINARY, 32'd3, 1'b0);
        queue_request(CMD_BINARY, 32'd2, 1'b0);
        queue_request(CMD_CLEAR, $urandom, 1'b0);
        queue_request(CMD_CLEAR, $urandom, 1'b0);

        // Long ascending run, then search both ends after a full drain
        acc = -64'sd2147483648 + longint'($urandom_range(1000));
        first_word = acc[31:0];
        last_word  = first_word;
        for (int i = 0; i < FILL_WORDS; i++) begin
            queue_request(CMD_APPEND, acc[31:0], 1'b0);
            last_word = acc[31:0];
            acc += longint'($urandom_range(1, 1 << 21));
        end
        queue_request(CMD_LINEAR, last_word, 1'b1);
        queue_request(CMD_LINEAR, last_word + 32'd1, 1'b0);
        queue_request(CMD_SORTED, last_word, 1'b0);
        queue_request(CMD_BINARY, last_word, 1'b0);
        queue_request(CMD_BINARY, first_word, 1'b0);
        queue_request(CMD_BINARY, first_word - 32'd1, 1'b0);
        queue_request(CMD_CLEAR, $urandom, 1'b0);

        // Random: mostly fill-then-search runs, some noise
        base = request_queue.size();
        while (request_queue.size() - base < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                if ($urandom_range(4) != 0) begin
                    queue_request(CMD_CLEAR, $urandom, 1'b0);
                    shadow.delete();
                end
                mode = $urandom_range(2);   // 0 ascending, 1 wide random, 2 narrow
                acc  = longint'($signed($urandom)) >>> 1;
                n    = $urandom_range(24);
                for (int i = 0; i < n; i++) begin
                    case (mode)
                        0: begin
                            val = acc[31:0];
                            acc += longint'($urandom_range(1 << 20));
                        end
                        1: val = $urandom;
                        default: val = 32'(int'($urandom_range(16)) - 8);
                    endcase
                    queue_request(CMD_APPEND, val, $urandom_range(99) < 2);
                    if (shadow.size() < CAPACITY) shadow.push_back(val);
                end
                m = $urandom_range(1, 8);
                for (int i = 0; i < m; i++) begin
                    cmd = CMD_LINEAR + 3'($urandom_range(2));
                    if (shadow.size() != 0 && $urandom_range(99) < 70) begin
                        key = shadow[$urandom_range(shadow.size() - 1)];
                        if ($urandom_range(3) == 0)
                            key = $urandom_range(1) ? key + 32'd1 : key - 32'd1;
                    end else if (mode == 2) begin
                        key = 32'(int'($urandom_range(16)) - 8);
                    end else begin
                        key = $urandom;
                    end
                    queue_request(cmd, key, $urandom_range(99) < 2);
                end
            end else begin
                cmd = 3'($urandom_range(7));
                val = $urandom;
                queue_request(cmd, val, 1'b0);
                if (cmd == CMD_CLEAR) shadow.delete();
                else if (cmd == CMD_APPEND && shadow.size() < CAPACITY) shadow.push_back(val);
            end
        end

        // Reset once
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || i_s_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/core/ats_pkg.sv
rtl/core/ats_ram.sv
rtl/core/array_table_search_engine.sv
test/tb_array_table_search_engine.sv
